// File: design/siph_pkg.sv
package siph_pkg;

   typedef struct packed {
      logic [63:0] a;
      logic [63:0] b;
      logic [63:0] c;
      logic [63:0] d;
   } lanes_type;

   localparam logic [63:0] LANE_A_INIT = 64'h736f6d6570736575;
   localparam logic [63:0] LANE_B_INIT = 64'h646f72616e646f6d;
   localparam logic [63:0] LANE_C_INIT = 64'h6c7967656e657261;
   localparam logic [63:0] LANE_D_INIT = 64'h7465646279746573;
   localparam logic [63:0] FINAL_XOR   = 64'h00000000000000ff;
   localparam logic [63:0] HASH_MINUS1 = 64'hffffffffffffffff;
   localparam logic [63:0] HASH_MINUS2 = 64'hfffffffffffffffe;
   localparam logic [2:0]  LAST_POS    = 3'd7;

   localparam lanes_type LANES_INIT = '{
      a: LANE_A_INIT, b: LANE_B_INIT, c: LANE_C_INIT, d: LANE_D_INIT
   };

   function automatic logic [63:0] rotl(input logic [63:0] x, input int unsigned n);
      rotl = (x << n) | (x >> (64 - n));
   endfunction

   // One SipRound.
   function automatic lanes_type lane_mix(input lanes_type s);
      lanes_type r;
      r = s;
      r.a = r.a + r.b;
      r.b = rotl(r.b, 13) ^ r.a;
      r.a = rotl(r.a, 32);
      r.c = r.c + r.d;
      r.d = rotl(r.d, 16) ^ r.c;
      r.a = r.a + r.d;
      r.d = rotl(r.d, 21) ^ r.a;
      r.c = r.c + r.b;
      r.b = rotl(r.b, 17) ^ r.c;
      r.c = rotl(r.c, 32);
      return r;
   endfunction

   // Compress one 64-bit message word with a single round.
   function automatic lanes_type sip_compress(input lanes_type s, input logic [63:0] w);
      lanes_type r;
      r   = s;
      r.d = r.d ^ w;
      r   = lane_mix(r);
      r.a = r.a ^ w;
      return r;
   endfunction

endpackage

// File: design/siphash13_byte_stream_hash_core.sv
// The end-of-message hash moves through s0..s3 and the output register to rsp_valid.
// Throughput: one transaction per cycle while req_ready is high; the byte absorb path
// does at most one SipRound per cycle; finalization is a four-stage round pipeline.
// Reset (synchronous, active high) loads the SipHash init lanes, clears the
// partial word, byte position, length and non-empty flag, and empties the pipeline.
module siphash13_byte_stream_hash_core
   import siph_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [7:0]         req_data_byte,
   input  logic               req_byte_present,
   input  logic               req_end_of_message,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [63:0] rsp_hash_value
);

   // ---------------------------------------------------------------
   // Absorb state: lanes, partial little-endian word, position, length
   // ---------------------------------------------------------------
   lanes_type   lane_ff, lane_in;
   logic [55:0] pword_ff, pword_in;
   logic [2:0]  bpos_ff, bpos_in;
   logic [7:0]  len_ff, len_in;
   logic        nonempty_ff, nonempty_in;

   // Finalization pipeline: s0 holds the snapshot with the final word
   // already XORed into lane d; s1..s3 and the output register each take one round.
   lanes_type   s0_lane_ff, s1_lane_ff, s2_lane_ff, s3_lane_ff;
   logic [63:0] s0_word_ff;
   logic [3:0]  v_ff;
   logic [3:0]  empty_ff;
   logic        rsp_valid_ff;
   logic [63:0] rsp_hash_ff;

   logic        ready_out;
   logic [3:0]  stage_ready;
   logic        accept;
   logic        accept_last;

   lanes_type   ab_lanes;
   logic [55:0] byte_shifted;
   logic [63:0] final_word;
   lanes_type   s1_calc, s2_calc, s3_calc, out_calc;
   logic [63:0] folded;

   // Each stage takes new data when it is empty or its contents move on.
   always_comb begin
      ready_out      = !rsp_valid_ff || rsp_ready;
      stage_ready[3] = !v_ff[3] || ready_out;
      stage_ready[2] = !v_ff[2] || stage_ready[3];
      stage_ready[1] = !v_ff[1] || stage_ready[2];
      stage_ready[0] = !v_ff[0] || stage_ready[1];
   end

   // Only an end-of-message transaction needs a pipeline slot, but keep
   // ready independent of the payload.
   assign req_ready   = stage_ready[0];
   assign accept      = req_valid && req_ready;
   assign accept_last = accept && req_end_of_message;

   // Absorb the byte; on the eighth byte compress the full word.
   always_comb begin
      ab_lanes     = lane_ff;
      pword_in     = pword_ff;
      bpos_in      = bpos_ff;
      len_in       = len_ff;
      nonempty_in  = nonempty_ff;
      byte_shifted = 56'(req_data_byte) << {bpos_ff, 3'b000};
      if (req_byte_present) begin
         nonempty_in = 1'b1;
         len_in      = len_ff + 8'd1;
         if (bpos_ff == LAST_POS) begin
            ab_lanes = sip_compress(lane_ff, {req_data_byte, pword_ff});
            pword_in = '0;
            bpos_in  = '0;
         end else begin
            pword_in = pword_ff | byte_shifted;
            bpos_in  = bpos_ff + 3'd1;
         end
      end
      // Pad the last word with the length in its top byte.
      final_word = {len_in, pword_in};
      lane_in    = ab_lanes;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lane_ff     <= LANES_INIT;
         pword_ff    <= '0;
         bpos_ff     <= '0;
         len_ff      <= '0;
         nonempty_ff <= 1'b0;
      end else if (accept) begin
         if (req_end_of_message) begin
            // Return to the initial state for the next message.
            lane_ff     <= LANES_INIT;
            pword_ff    <= '0;
            bpos_ff     <= '0;
            len_ff      <= '0;
            nonempty_ff <= 1'b0;
         end else begin
            lane_ff     <= lane_in;
            pword_ff    <= pword_in;
            bpos_ff     <= bpos_in;
            len_ff      <= len_in;
            nonempty_ff <= nonempty_in;
         end
      end
   end

   // ---------------------------------------------------------------
   // Finalization rounds
   // ---------------------------------------------------------------
   always_comb begin
      s1_calc   = lane_mix(s0_lane_ff);
      s1_calc.a = s1_calc.a ^ s0_word_ff;
      s1_calc.c = s1_calc.c ^ FINAL_XOR;
      s2_calc   = lane_mix(s1_lane_ff);
      s3_calc   = lane_mix(s2_lane_ff);
      out_calc  = lane_mix(s3_lane_ff);
      folded    = out_calc.a ^ out_calc.b ^ out_calc.c ^ out_calc.d;
      if (folded == HASH_MINUS1) begin
         folded = HASH_MINUS2;
      end
   end

   // Control: valid bits and output valid.
   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (stage_ready[0]) begin
            v_ff[0] <= accept_last;
         end
         if (stage_ready[1]) begin
            v_ff[1] <= v_ff[0];
         end
         if (stage_ready[2]) begin
            v_ff[2] <= v_ff[1];
         end
         if (stage_ready[3]) begin
            v_ff[3] <= v_ff[2];
         end
         if (ready_out) begin
            rsp_valid_ff <= v_ff[3];
         end
      end
   end

   // Payload: advance each stage with its ready, no reset needed.
   always_ff @(posedge clock) begin
      if (stage_ready[0]) begin
         s0_lane_ff   <= '{a: ab_lanes.a, b: ab_lanes.b, c: ab_lanes.c,
                           d: ab_lanes.d ^ final_word};
         s0_word_ff   <= final_word;
         empty_ff[0]  <= !nonempty_in;
      end
      if (stage_ready[1]) begin
         s1_lane_ff  <= s1_calc;
         empty_ff[1] <= empty_ff[0];
      end
      if (stage_ready[2]) begin
         s2_lane_ff  <= s2_calc;
         empty_ff[2] <= empty_ff[1];
      end
      if (stage_ready[3]) begin
         s3_lane_ff  <= s3_calc;
         empty_ff[3] <= empty_ff[2];
      end
      if (ready_out) begin
         // An empty message hashes to zero.
         rsp_hash_ff <= empty_ff[3] ? '0 : folded;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_hash_value = $signed(rsp_hash_ff);

`ifndef SYNTH
   a_last_enters_pipe: assert property (@(posedge clock) disable iff (reset)
      accept_last |=> v_ff[0])
      else $error("end-of-message transaction did not enter the finalization pipeline");

   a_state_cleared: assert property (@(posedge clock) disable iff (reset)
      accept_last |=> (bpos_ff == '0 && len_ff == '0 && !nonempty_ff && pword_ff == '0))
      else $error("absorb state not returned to initial after end of message");

   a_never_minus_one: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_hash_ff != HASH_MINUS1)
      else $error("hash of minus one emitted");

   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      (v_ff[3] && empty_ff[3] && ready_out) |=> (rsp_valid && rsp_hash_ff == '0))
      else $error("empty message did not yield zero");
`endif

endmodule

// File: tb/sv/testbench.sv
module testbench;
   import siph_pkg::*;

   // SipHash-1-3 initial lanes for an all-zero key
   localparam logic [63:0] SEED_A        = 64'h736f6d6570736575;
   localparam logic [63:0] SEED_B        = 64'h646f72616e646f6d;
   localparam logic [63:0] SEED_C        = 64'h6c7967656e657261;
   localparam logic [63:0] SEED_D        = 64'h7465646279746573;
   localparam logic [63:0] FINALIZE_MARK = 64'h00000000000000ff;
   localparam logic [63:0] ALL_ONES_HASH = 64'hffffffffffffffff;
   localparam logic [63:0] NEG_TWO_HASH  = 64'hfffffffffffffffe;

   localparam int ITEM_TARGET    = 1850;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = 12;
   localparam int GAP_PCT        = 30;

   // Predicts the hash of each message from the transactions seen on the
   // request channel and holds the hashes still owed by the block.
   class hash_scoreboard;
      logic [63:0] va, vb, vc, vd;
      logic [55:0] tail_bytes;
      logic [2:0]  tail_count;
      logic [7:0]  length_mod;
      bit          seen_byte;
      logic [63:0] expected_hashes[$];
      int          failures;

      function new();
         failures = 0;
         restart();
      endfunction

      function void restart();
         va         = SEED_A;
         vb         = SEED_B;
         vc         = SEED_C;
         vd         = SEED_D;
         tail_bytes = '0;
         tail_count = '0;
         length_mod = '0;
         seen_byte  = 1'b0;
      endfunction

      function logic [63:0] rol64(input logic [63:0] x, input int n);
         return (x << n) | (x >> (64 - n));
      endfunction

      function void mix_round();
         va = va + vb;
         vb = rol64(vb, 13) ^ va;
         va = rol64(va, 32);
         vc = vc + vd;
         vd = rol64(vd, 16) ^ vc;
         va = va + vd;
         vd = rol64(vd, 21) ^ va;
         vc = vc + vb;
         vb = rol64(vb, 17) ^ vc;
         vc = rol64(vc, 32);
      endfunction

      function void absorb_word(input logic [63:0] w);
         vd = vd ^ w;
         mix_round();
         va = va ^ w;
      endfunction

      // Note one accepted request transaction; queue a hash on end of message.
      function void note_item(input logic [7:0] b, input logic present, input logic last);
         logic [63:0] digest;
         if (present) begin
            seen_byte  = 1'b1;
            length_mod = length_mod + 8'd1;
            if (tail_count == 3'd7) begin
               absorb_word({b, tail_bytes});
               tail_bytes = '0;
               tail_count = '0;
            end else begin
               tail_bytes[tail_count * 8 +: 8] = b;
               tail_count = tail_count + 3'd1;
            end
         end
         if (last) begin
            if (!seen_byte) begin
               digest = '0;
            end else begin
               absorb_word({length_mod, tail_bytes});
               vc = vc ^ FINALIZE_MARK;
               mix_round();
               mix_round();
               mix_round();
               digest = va ^ vb ^ vc ^ vd;
               if (digest == ALL_ONES_HASH) digest = NEG_TWO_HASH;
            end
            expected_hashes.push_back(digest);
            restart();
         end
      endfunction

      function void check_hash(input logic [63:0] actual);
         logic [63:0] wanted;
         if (expected_hashes.size() == 0) begin
            $error("hash_value arrived with no message pending: actual %h", actual);
            failures++;
         end else begin
            wanted = expected_hashes.pop_front();
            if (actual !== wanted) begin
               $error("hash_value mismatch: expected %h, actual %h", wanted, actual);
               failures++;
            end
         end
      endfunction

      function int pending();
         return expected_hashes.size();
      endfunction
   endclass

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   logic [7:0]         req_data_byte;
   logic               req_byte_present;
   logic               req_end_of_message;
   logic               rsp_valid;
   logic               rsp_ready;
   logic signed [63:0] rsp_hash_value;

   hash_scoreboard hash_board;
   int             sent_items;
   int             idle_cycles;
   int             ready_cycle;

   siphash13_byte_stream_hash_core uut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_data_byte      (req_data_byte),
      .req_byte_present   (req_byte_present),
      .req_end_of_message (req_end_of_message),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_hash_value     (rsp_hash_value)
   );

   initial clock = 1'b0;
   always #6 clock = ~clock;

   // Offer one request transaction and hold it until the block takes it.
   // Idle the channel at random first, except in a calm window of items
   // that lets the block see back-to-back traffic.
   task automatic send_item(input logic [7:0] b, input logic present, input logic last);
      bit calm;
      calm = (sent_items >= 700) && (sent_items < 1100);
      while (!calm && $urandom_range(0, 99) < GAP_PCT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_data_byte      <= b;
      req_byte_present   <= present;
      req_end_of_message <= last;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sent_items++;
   endtask

   // Send one message of n_bytes bytes, with idle transactions mixed in as
   // noise. Either the last byte carries the end flag or a byte-less end
   // transaction closes the message.
   task automatic send_message(input int n_bytes, input int noise_pct, input bit end_on_byte);
      int k;
      for (k = 0; k < n_bytes; k++) begin
         if ($urandom_range(0, 99) < noise_pct)
            send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
         send_item(8'($urandom_range(0, 255)), 1'b1, end_on_byte && (k == n_bytes - 1));
      end
      if (n_bytes == 0 || !end_on_byte)
         send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
   endtask

   // Response side: stall at random, but keep a window of cycles where the
   // block always sees ready.
   always @(posedge clock) begin
      ready_cycle <= ready_cycle + 1;
      if (ready_cycle >= 1000 && ready_cycle < 1600)
         rsp_ready <= 1'b1;
      else
         rsp_ready <= ($urandom_range(0, 99) >= GAP_PCT);
   end

   // Monitor both channels at the edge, and end the run if nothing moves
   // for too long.
   always @(posedge clock) begin
      if (reset) begin
         idle_cycles <= 0;
      end else begin
         if (req_valid && req_ready)
            hash_board.note_item(req_data_byte, req_byte_present, req_end_of_message);
         if (rsp_valid && rsp_ready)
            hash_board.check_hash(rsp_hash_value);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL siphash13_byte_stream_hash_core");
            $finish;
         end
      end
   end

   initial begin
      int pick;
      int len;
      int k;

      hash_board         = new();
      sent_items         = 0;
      reset              = 1'b1;
      req_valid          = 1'b0;
      req_data_byte      = '0;
      req_byte_present   = 1'b0;
      req_end_of_message = 1'b0;

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty message, idle transaction, then another empty message.
      send_item(8'h5a, 1'b0, 1'b1);
      send_item(8'ha5, 1'b0, 1'b0);
      send_item(8'h00, 1'b0, 1'b1);
      // Single-byte messages at the byte extremes, end flag on the byte.
      send_item(8'h00, 1'b1, 1'b1);
      send_item(8'hff, 1'b1, 1'b1);
      // Seven bytes with an idle in the middle, then a byte-less end:
      // the final word is padded with no compression before it.
      for (k = 0; k < 7; k++) begin
         if (k == 3) send_item(8'hff, 1'b0, 1'b0);
         send_item((k % 2 == 0) ? 8'hff : 8'h00, 1'b1, 1'b0);
      end
      send_item(8'h00, 1'b0, 1'b1);
      // Exactly one full word, end flag on the eighth byte.
      for (k = 0; k < 8; k++)
         send_item((k % 2 == 0) ? 8'h00 : 8'hff, 1'b1, k == 7);

      // Wrap the length counter past 256 at least once.
      send_message(257, 5, 1'b1);

      // Random messages: mostly short, some empty, a few long ones.
      while (sent_items < ITEM_TARGET) begin
         pick = $urandom_range(0, 99);
         if (pick < 2)
            len = $urandom_range(248, 264);
         else if (pick < 10)
            len = 0;
         else
            len = $urandom_range(1, 24);
         send_message(len, 8, 1'($urandom_range(0, 1)));
      end
      req_valid <= 1'b0;
      // Let the monitor note the last transaction before counting what is owed.
      @(posedge clock);

      // Drain: wait for every owed hash, then keep waiting for any strays.
      while (hash_board.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (hash_board.failures == 0 && hash_board.pending() == 0)
         $display("PASS siphash13_byte_stream_hash_core");
      else
         $display("FAIL siphash13_byte_stream_hash_core");
      $finish;
   end

endmodule

// File: files.f
design/siph_pkg.sv
design/siphash13_byte_stream_hash_core.sv
tb/sv/testbench.sv
